// File: src/mi3_pkg.sv
// Shared types and constants for the 3x3 matrix inverse block.
// It has no dependencies. The front, queue, back and top level files use it.
package mi3_pkg;

   localparam int ENTRIES    = 9;
   localparam int DATA_W     = 16;  // Q4.12 entry
   localparam int PROD_W     = 32;  // entry * entry
   localparam int COF_W      = 33;  // signed cofactor, scale 2^24
   localparam int CMAG_W     = 32;  // cofactor magnitude
   localparam int DTERM_W    = 49;  // entry * cofactor
   localparam int DSUM_W     = 51;  // sum of three expansion terms
   localparam int DET_W      = 49;  // determinant, Q13.36
   localparam int THR_W      = 37;
   localparam int INV_W      = 32;  // Q16.16 result
   localparam int QUO_W      = 33;  // quotient bits kept, one above the result range
   localparam int DIV_STEPS  = QUO_W;
   localparam int REM_W      = DET_W + 1;  // twice the determinant magnitude
   localparam int NUM_SHIFT  = 29;  // cofactor * 2^28, doubled for rounding
   localparam int NUM_W      = CMAG_W + NUM_SHIFT + 1;
   localparam int DET_TERMS  = 3;

   localparam logic [THR_W-1:0] THR_RESET   = 37'd687195;
   localparam logic [QUO_W-1:0] SAT_NEG_MAG = 33'h0_8000_0000;
   localparam logic [QUO_W-1:0] SAT_POS_MAG = 33'h0_7FFF_FFFF;
   localparam logic [INV_W-1:0] INV_POS_MAX = 32'h7FFF_FFFF;

   localparam int QUEUE_DEPTH_DEF = 4;

   // Entry order: a00 a01 a02 a10 a11 a12 a20 a21 a22.
   // Cofactor k = entry[PA_L]*entry[PA_R] - entry[PB_L]*entry[PB_R]; transposed (adjugate).
   localparam int PA_L [ENTRIES] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
   localparam int PA_R [ENTRIES] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
   localparam int PB_L [ENTRIES] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
   localparam int PB_R [ENTRIES] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};
   // Determinant by expansion along column 0 against adjugate entries 0, 1, 2.
   localparam int DET_ROW [DET_TERMS] = '{0, 3, 6};

   typedef logic [ENTRIES-1:0][DATA_W-1:0] mi3_mat_type;

   typedef struct packed {
      logic [ENTRIES-1:0]             neg;
      logic [ENTRIES-1:0][CMAG_W-1:0] cof_mag;
      logic [DET_W-1:0]               det;
      logic [DET_W-1:0]               det_mag;
      logic                           singular;
   } mi3_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } mi3_qstat_type;

endpackage

// File: src/matrix3_inverse.sv
// Top level of the 3x3 matrix inverse: threshold register, front, queue and back parts.
// Depends on mi3_pkg, mi3_front, mi3_queue and mi3_back.
//
//   port group  direction  handshake          carries
//   req_*       in         req_valid/stall    nine Q4.12 entries
//   rsp_*       out        rsp_valid/stall    nine Q16.16 entries, determinant, singular
//   csr_*       in         csr_wr_en          singular threshold, Q.36
//
// One matrix enters per cycle while the input is not stalled; a result passes five front
// stages, the queue, 34 divider stages (operand setup, then one quotient bit each for
// 33 bits) and the output register.
// Reset clears control state and loads the threshold; there is no clearing pass.
// A result stall freezes the back part; the queue then fills and the front part
// stalls the input once its last stage cannot push.
module matrix3_inverse #(
   parameter int QUEUE_DEPTH = mi3_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [mi3_pkg::DATA_W-1:0]  req_a00,
   input  logic signed [mi3_pkg::DATA_W-1:0]  req_a01,
   input  logic signed [mi3_pkg::DATA_W-1:0]  req_a02,
   input  logic signed [mi3_pkg::DATA_W-1:0]  req_a10,
   input  logic signed [mi3_pkg::DATA_W-1:0]  req_a11,
   input  logic signed [mi3_pkg::DATA_W-1:0]  req_a12,
   input  logic signed [mi3_pkg::DATA_W-1:0]  req_a20,
   input  logic signed [mi3_pkg::DATA_W-1:0]  req_a21,
   input  logic signed [mi3_pkg::DATA_W-1:0]  req_a22,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [mi3_pkg::INV_W-1:0]   rsp_inv00,
   output logic signed [mi3_pkg::INV_W-1:0]   rsp_inv01,
   output logic signed [mi3_pkg::INV_W-1:0]   rsp_inv02,
   output logic signed [mi3_pkg::INV_W-1:0]   rsp_inv10,
   output logic signed [mi3_pkg::INV_W-1:0]   rsp_inv11,
   output logic signed [mi3_pkg::INV_W-1:0]   rsp_inv12,
   output logic signed [mi3_pkg::INV_W-1:0]   rsp_inv20,
   output logic signed [mi3_pkg::INV_W-1:0]   rsp_inv21,
   output logic signed [mi3_pkg::INV_W-1:0]   rsp_inv22,
   output logic signed [mi3_pkg::DET_W-1:0]   rsp_determinant,
   output logic                               rsp_singular,
   input  logic                               csr_wr_en,
   input  logic [mi3_pkg::THR_W-1:0]          csr_wr_data
);
   import mi3_pkg::*;

   logic [THR_W-1:0]              thr_ff;
   mi3_mat_type                   mat;
   mi3_qstat_type                 q_stat;
   mi3_job_type                   push_job, pop_job;
   logic                          push, pop;
   logic [ENTRIES-1:0][INV_W-1:0] inv;
   logic [DET_W-1:0]              det;

   // Threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   assign mat = {req_a22, req_a21, req_a20, req_a12, req_a11, req_a10,
                 req_a02, req_a01, req_a00};

   mi3_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mat   (mat),
      .threshold (thr_ff),
      .q_stat    (q_stat),
      .push      (push),
      .push_job  (push_job)
   );

   mi3_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .q_stat   (q_stat)
   );

   mi3_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_stat       (q_stat),
      .pop          (pop),
      .pop_job      (pop_job),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_inv      (inv),
      .rsp_det      (det),
      .rsp_singular (rsp_singular)
   );

   assign rsp_inv00       = inv[0];
   assign rsp_inv01       = inv[1];
   assign rsp_inv02       = inv[2];
   assign rsp_inv10       = inv[3];
   assign rsp_inv11       = inv[4];
   assign rsp_inv12       = inv[5];
   assign rsp_inv20       = inv[6];
   assign rsp_inv21       = inv[7];
   assign rsp_inv22       = inv[8];
   assign rsp_determinant = det;

   // Singular results carry a zero inverse (checked on the diagonal entries)
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_inv00 == '0 && rsp_inv11 == '0 && rsp_inv22 == '0)
      else $error("singular result with nonzero inverse");

   // A zero determinant is always flagged singular
   a_zero_det: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_determinant == '0 |-> rsp_singular)
      else $error("zero determinant not flagged singular");

   // Queue is never both full and empty, and never pushed while full
   a_queue: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty) && !(push && q_stat.full))
      else $error("queue status inconsistent");

   // Pop only from a non-empty queue
   a_pop: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("pop from empty queue");

endmodule

// File: src/mi3_front.sv
// Front part: accepts matrices, forms cofactors and determinant, classifies singular.
// Depends on mi3_pkg; feeds mi3_queue.
module mi3_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  mi3_pkg::mi3_mat_type       req_mat,
   input  logic [mi3_pkg::THR_W-1:0]  threshold,
   input  mi3_pkg::mi3_qstat_type     q_stat,
   output logic                       push,
   output mi3_pkg::mi3_job_type       push_job
);
   import mi3_pkg::*;

   localparam int STAGES = 5;

   logic [STAGES-1:0] vld_ff, vld_in;
   logic              en;

   logic signed [DATA_W-1:0]  s1_a_ff [ENTRIES];
   logic signed [DATA_W-1:0]  s2_a_ff [ENTRIES];
   logic signed [PROD_W-1:0]  s2_pa_ff [ENTRIES], s2_pa_in [ENTRIES];
   logic signed [PROD_W-1:0]  s2_pb_ff [ENTRIES], s2_pb_in [ENTRIES];
   logic signed [DATA_W-1:0]  s3_a_ff [DET_TERMS];
   logic signed [COF_W-1:0]   s3_cof_ff [ENTRIES], s3_cof_in [ENTRIES];
   logic signed [COF_W-1:0]   s4_cof_ff [ENTRIES];
   logic signed [DTERM_W-1:0] s4_dt_ff [DET_TERMS], s4_dt_in [DET_TERMS];
   logic [ENTRIES-1:0]        s5_neg_ff, s5_neg_in;
   logic [CMAG_W-1:0]         s5_mag_ff [ENTRIES], s5_mag_in [ENTRIES];
   logic signed [DSUM_W-1:0]  s5_det_ff, s5_det_in;
   logic [DSUM_W-1:0]         det_abs;

   // Advance unless the last stage holds an item the queue cannot take
   assign en        = !vld_ff[STAGES-1] || !q_stat.full;
   assign req_stall = !en;
   assign push      = vld_ff[STAGES-1] && !q_stat.full;
   assign vld_in    = {vld_ff[STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Form products, cofactors, expansion terms, cofactor magnitudes and the determinant sum
   always_comb begin
      logic [COF_W-1:0] cabs;
      cabs = '0;
      for (int k = 0; k < ENTRIES; k++) begin
         s2_pa_in[k]  = s1_a_ff[PA_L[k]] * s1_a_ff[PA_R[k]];
         s2_pb_in[k]  = s1_a_ff[PB_L[k]] * s1_a_ff[PB_R[k]];
         s3_cof_in[k] = COF_W'(s2_pa_ff[k]) - COF_W'(s2_pb_ff[k]);
         s5_neg_in[k] = s4_cof_ff[k][COF_W-1];
         cabs         = s4_cof_ff[k][COF_W-1] ? (~s4_cof_ff[k] + 1'b1) : s4_cof_ff[k];
         s5_mag_in[k] = cabs[CMAG_W-1:0];
      end
      for (int t = 0; t < DET_TERMS; t++) begin
         s4_dt_in[t] = DTERM_W'(s3_a_ff[t]) * DTERM_W'(s3_cof_ff[t]);
      end
      s5_det_in = DSUM_W'(s4_dt_ff[0]) + DSUM_W'(s4_dt_ff[1]) + DSUM_W'(s4_dt_ff[2]);
   end

   // Hold stage payload while stalled
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < ENTRIES; k++) begin
            s1_a_ff[k]   <= req_mat[k];
            s2_a_ff[k]   <= s1_a_ff[k];
            s2_pa_ff[k]  <= s2_pa_in[k];
            s2_pb_ff[k]  <= s2_pb_in[k];
            s3_cof_ff[k] <= s3_cof_in[k];
            s4_cof_ff[k] <= s3_cof_ff[k];
            s5_mag_ff[k] <= s5_mag_in[k];
         end
         for (int t = 0; t < DET_TERMS; t++) begin
            s3_a_ff[t]  <= s2_a_ff[DET_ROW[t]];
            s4_dt_ff[t] <= s4_dt_in[t];
         end
         s5_neg_ff <= s5_neg_in;
         s5_det_ff <= s5_det_in;
      end
   end

   // Classify against the threshold on the way into the queue
   assign det_abs = s5_det_ff[DSUM_W-1] ? (~s5_det_ff + 1'b1) : s5_det_ff;

   always_comb begin
      // Quotient sign is cofactor sign flipped by determinant sign
      push_job.neg = s5_neg_ff ^ {ENTRIES{s5_det_ff[DSUM_W-1]}};
      for (int k = 0; k < ENTRIES; k++) begin
         push_job.cof_mag[k] = s5_mag_ff[k];
      end
      push_job.det      = s5_det_ff[DET_W-1:0];
      push_job.det_mag  = det_abs[DET_W-1:0];
      push_job.singular = det_abs[DET_W-1:0] <= DET_W'(threshold);
   end

endmodule

// File: src/mi3_queue.sv
// Short queue between front and back parts of the matrix inverse block.
// Depends on mi3_pkg for the item and status types.
module mi3_queue #(
   parameter int DEPTH = mi3_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mi3_pkg::mi3_job_type   push_job,
   input  logic                   pop,
   output mi3_pkg::mi3_job_type   pop_job,
   output mi3_pkg::mi3_qstat_type q_stat
);
   import mi3_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   mi3_job_type     mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   // Advance pointers with wrap, track fill
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign pop_job      = mem_ff[rd_ptr_ff];
   assign q_stat.full  = count_ff == CW'(DEPTH);
   assign q_stat.empty = count_ff == '0;

endmodule

// File: src/mi3_back.sv
// Back part: nine pipelined restoring dividers, one quotient bit per stage, then saturation.
// Depends on mi3_pkg; drains mi3_queue and drives the result channel.
module mi3_back (
   input  logic                                             clock,
   input  logic                                             reset,
   input  mi3_pkg::mi3_qstat_type                           q_stat,
   output logic                                             pop,
   input  mi3_pkg::mi3_job_type                             pop_job,
   output logic                                             rsp_valid,
   input  logic                                             rsp_stall,
   output logic [mi3_pkg::ENTRIES-1:0][mi3_pkg::INV_W-1:0]  rsp_inv,
   output logic [mi3_pkg::DET_W-1:0]                        rsp_det,
   output logic                                             rsp_singular
);
   import mi3_pkg::*;

   logic en;
   logic [DIV_STEPS:0] vld_ff, vld_in;
   logic               rsp_valid_ff;

   logic [REM_W-1:0]   rem_ff [DIV_STEPS+1][ENTRIES], rem_in [DIV_STEPS+1][ENTRIES];
   logic [QUO_W-1:0]   low_ff [DIV_STEPS+1][ENTRIES], low_in [DIV_STEPS+1][ENTRIES];
   logic [QUO_W-1:0]   quo_ff [DIV_STEPS+1][ENTRIES], quo_in [DIV_STEPS+1][ENTRIES];
   logic [REM_W-1:0]   dvs_ff [DIV_STEPS+1], dvs_in [DIV_STEPS+1];
   logic [ENTRIES-1:0] ov_ff [DIV_STEPS+1], ov_in [DIV_STEPS+1];
   logic [ENTRIES-1:0] neg_ff [DIV_STEPS+1], neg_in [DIV_STEPS+1];
   logic [DET_W-1:0]   det_ff [DIV_STEPS+1], det_in [DIV_STEPS+1];
   logic               sing_ff [DIV_STEPS+1], sing_in [DIV_STEPS+1];

   logic [ENTRIES-1:0][INV_W-1:0] inv_ff, inv_in;
   logic [DET_W-1:0]              rdet_ff;
   logic                          rsing_ff;

   // Advance whole back pipeline when the output register is free or taken
   assign en     = !rsp_valid_ff || !rsp_stall;
   assign pop    = en && !q_stat.empty;
   assign vld_in = {vld_ff[DIV_STEPS-1:0], pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[DIV_STEPS];
      end
   end

   // Set up numerator 2|n|+|d| and divisor 2|d|, then one restoring step per stage
   always_comb begin
      logic [NUM_W-1:0] num;
      logic [REM_W:0]   trial;
      logic [REM_W:0]   dext;
      logic [QUO_W:0]   mag;
      num   = '0;
      trial = '0;
      dext  = '0;
      mag   = '0;
      dvs_in[0]  = {pop_job.det_mag, 1'b0};
      neg_in[0]  = pop_job.neg;
      det_in[0]  = pop_job.det;
      sing_in[0] = pop_job.singular;
      for (int l = 0; l < ENTRIES; l++) begin
         num = NUM_W'({pop_job.cof_mag[l], NUM_SHIFT'(0)}) + NUM_W'(pop_job.det_mag);
         rem_in[0][l] = REM_W'(num[NUM_W-1:QUO_W]);
         low_in[0][l] = num[QUO_W-1:0];
         quo_in[0][l] = '0;
         ov_in[0][l]  = REM_W'(num[NUM_W-1:QUO_W]) >= dvs_in[0];
      end
      for (int s = 1; s <= DIV_STEPS; s++) begin
         dvs_in[s]  = dvs_ff[s-1];
         ov_in[s]   = ov_ff[s-1];
         neg_in[s]  = neg_ff[s-1];
         det_in[s]  = det_ff[s-1];
         sing_in[s] = sing_ff[s-1];
         dext       = {1'b0, dvs_ff[s-1]};
         for (int l = 0; l < ENTRIES; l++) begin
            trial = {rem_ff[s-1][l], low_ff[s-1][l][QUO_W-1]};
            low_in[s][l] = {low_ff[s-1][l][QUO_W-2:0], 1'b0};
            if (trial >= dext) begin
               rem_in[s][l] = REM_W'(trial - dext);
               quo_in[s][l] = {quo_ff[s-1][l][QUO_W-2:0], 1'b1};
            end else begin
               rem_in[s][l] = REM_W'(trial);
               quo_in[s][l] = {quo_ff[s-1][l][QUO_W-2:0], 1'b0};
            end
         end
      end
      // Apply sign, saturate, zero out singular matrices
      for (int l = 0; l < ENTRIES; l++) begin
         if (sing_ff[DIV_STEPS]) begin
            inv_in[l] = '0;
         end else if (neg_ff[DIV_STEPS][l]) begin
            if (ov_ff[DIV_STEPS][l] || quo_ff[DIV_STEPS][l] > SAT_NEG_MAG) begin
               mag = {1'b0, SAT_NEG_MAG};
            end else begin
               mag = {1'b0, quo_ff[DIV_STEPS][l]};
            end
            mag       = ~mag + 1'b1;
            inv_in[l] = mag[INV_W-1:0];
         end else begin
            if (ov_ff[DIV_STEPS][l] || quo_ff[DIV_STEPS][l] > SAT_POS_MAG) begin
               inv_in[l] = INV_POS_MAX;
            end else begin
               inv_in[l] = quo_ff[DIV_STEPS][l][INV_W-1:0];
            end
         end
      end
   end

   // Hold all stages and the output while stalled
   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s <= DIV_STEPS; s++) begin
            dvs_ff[s]  <= dvs_in[s];
            ov_ff[s]   <= ov_in[s];
            neg_ff[s]  <= neg_in[s];
            det_ff[s]  <= det_in[s];
            sing_ff[s] <= sing_in[s];
            for (int l = 0; l < ENTRIES; l++) begin
               rem_ff[s][l] <= rem_in[s][l];
               low_ff[s][l] <= low_in[s][l];
               quo_ff[s][l] <= quo_in[s][l];
            end
         end
         inv_ff   <= inv_in;
         rdet_ff  <= det_ff[DIV_STEPS];
         rsing_ff <= sing_ff[DIV_STEPS];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_inv      = inv_ff;
   assign rsp_det      = rdet_ff;
   assign rsp_singular = rsing_ff;

endmodule
